[sv/cfm_pkg.sv]
package cfm_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MID     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 3'd6;

  // Register widths and reset values
  localparam int CLK_W  = 24;
  localparam int WCFG_W = 7;
  localparam int PPR_W  = 8;

  localparam logic [CLK_W-1:0]  RST_TIMER_CLOCK = 24'd100000;
  localparam logic [CLK_W-1:0]  RST_LOW_BAND    = 24'd100;
  localparam logic [CLK_W-1:0]  RST_HIGH_BAND   = 24'd1000;
  localparam logic [WCFG_W-1:0] RST_WINDOW_LOW  = 7'd4;
  localparam logic [WCFG_W-1:0] RST_WINDOW_MID  = 7'd16;
  localparam logic [WCFG_W-1:0] RST_WINDOW_HIGH = 7'd64;
  localparam logic [PPR_W-1:0]  RST_PPR         = 8'd1;

  // Input item
  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_CAPTURE  = 1'b1;

  localparam int CAP_W       = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int PENDING_BIT = 16;

  // Result item, field positions in the output tdata
  localparam int FREQ_W      = 32;
  localparam int HZ_W        = 24;
  localparam int RPM_W       = 30;
  localparam int NWIN_W      = 7;
  localparam int RAW_LSB     = 0;
  localparam int SMOOTH_LSB  = 32;
  localparam int HZ_LSB      = 64;
  localparam int RPM_LSB     = 88;
  localparam int NWIN_LSB    = 118;
  localparam int OUT_TDATA_W = 128;

  localparam int Q8_BITS = 8;

  // Shared divider
  localparam int DIV_W = 40;
  localparam int DVS_W = 32;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/cfm_div.sv]
// Restoring divider, one quotient bit per cycle. The quotient is valid from
// the cycle in which done is high until the next start.
module cfm_div
  import cfm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             active_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DIV_W-1:0] quo_q, quo_d;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    fits    = ~diff[DVS_W+1];
    rem_d   = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_d   = {quo_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= active_q && !req_i.start && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= CNT_W'(DIV_W);
      end else if (active_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (active_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[sv/capture_frequency_meter.sv]
// Reciprocal frequency meter with adaptive averaging. Each input item is
// either a timer overflow tick or a capture edge carrying the 16-bit timer
// count; overflow ticks extend it to a 32-bit timestamp. After window+1
// capture edges the block emits one result item: the window frequency
// clock*window*256/ticks in unsigned Q.8 (rounded, saturated), a moving
// average over up to SMOOTH_DEPTH results, the average rounded to Hz, rpm,
// the window chosen for the next measurement from the frequency bands, and a
// flag that tells when a jump (below half or above twice the last value)
// restarted the average. Overflow ticks and capture edges that do not close a
// window leave the input side ready. An edge that closes a window with a
// nonzero span keeps the input side not ready until its result is in the
// output register, longer while an earlier result still waits: three
// divisions of 40 quotient bits run one after the other on a single shared
// restoring divider, and the average is summed from the history memory one
// entry at a time, a read and then an add per entry. A finished result waits
// in the output register while further items are taken; the block stalls
// only if a second result is ready before the first has been taken.
module capture_frequency_meter
  import cfm_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SMOOTH_DEPTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input items
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [15:0] capture_value, [16] overflow_pending, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] operation
  input  logic [0:0]             s_axis_tuser_i,
  // Result items
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [31:0] raw_freq_q8, [63:32] smooth_freq_q8, [87:64] freq_hz,
  // [117:88] rpm, [124:118] next_window, [127:125] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] smoothing_cleared
  output logic [0:0]             m_axis_tuser_o,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int FILL_W = $clog2(SMOOTH_DEPTH + 1);
  localparam int ACC_W  = FREQ_W + $clog2(SMOOTH_DEPTH);
  localparam int PROD_W = CLK_W + WIN_W;

  localparam logic [WIN_W-1:0]  MaxWin   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0]  WinReset = (int'(RST_WINDOW_MID) > MAX_WINDOW) ?
                                           WIN_W'(MAX_WINDOW) : WIN_W'(RST_WINDOW_MID);
  localparam logic [IDX_W-1:0]  LastIdx  = IDX_W'(SMOOTH_DEPTH - 1);
  localparam logic [FILL_W-1:0] FullFill = FILL_W'(SMOOTH_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RAW_GO,
    ST_RAW_WAIT,
    ST_BAND,
    ST_STORE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_HZ,
    ST_RPM_GO,
    ST_RPM_WAIT,
    ST_OUT
  } state_e;

  // A window register of zero acts as one; above the maximum it saturates.
  function automatic logic [WIN_W-1:0] clamp_win(input logic [WCFG_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if (w > WCFG_W'(MAX_WINDOW)) begin
      r = MaxWin;
    end else begin
      r = WIN_W'(w);
    end
    return r;
  endfunction

  function automatic logic [FREQ_W-1:0] sat_freq(input logic [DIV_W-1:0] q);
    logic [FREQ_W-1:0] r;
    r = (|q[DIV_W-1:FREQ_W]) ? '1 : q[FREQ_W-1:0];
    return r;
  endfunction

  // Configuration registers
  logic [CLK_W-1:0]  timer_clock_q, low_band_q, high_band_q;
  logic [WCFG_W-1:0] window_low_q, window_mid_q, window_high_q;
  logic [PPR_W-1:0]  ppr_q;

  // Measurement state
  state_e            state_q;
  logic [CAP_W-1:0]  ovf_cnt_q;
  logic [31:0]       first_ts_q;
  logic [WIN_W-1:0]  edge_cnt_q;
  logic [WIN_W-1:0]  window_size_q;
  logic [31:0]       ticks_q;
  logic [WIN_W-1:0]  win_q;
  logic [PROD_W-1:0] prod_q;
  logic [FREQ_W-1:0] raw_q;
  logic [FREQ_W-1:0] last_q;
  logic              cleared_q;
  logic [IDX_W-1:0]  pos_q;
  logic [FILL_W-1:0] fill_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ACC_W-1:0]  acc_q;
  logic [FREQ_W-1:0] smooth_q;
  logic [HZ_W-1:0]   hz_q;
  logic [RPM_W-1:0]  rpm_q;

  // Output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_user_q;

  // History of recent results
  logic [FREQ_W-1:0] ring_mem [SMOOTH_DEPTH];
  logic [FREQ_W-1:0] ring_rd_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Timestamp of the edge being accepted
  logic [CAP_W-1:0]  cap_val;
  logic              cap_pending;
  logic [CAP_W-1:0]  ovf_sel;
  logic [31:0]       timestamp;
  logic [31:0]       ticks;
  logic              in_fire;

  // Combinational helpers for the later steps
  logic              jump;
  logic [IDX_W-1:0]  wr_pos;
  logic [FREQ_W:0]   hz_sum;
  logic [RPM_W-1:0]  hz_x60;
  logic [PPR_W-1:0]  ppr_eff;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign cap_val     = s_axis_tdata_i[CAP_W-1:0];
  assign cap_pending = s_axis_tdata_i[PENDING_BIT];

  always_comb begin
    // An overflow that the timer flagged as pending takes this edge's overflow
    // count one lower, but only when the capture sits in the lower half of the count.
    ovf_sel   = ovf_cnt_q - CAP_W'(cap_pending && !cap_val[CAP_W-1]);
    timestamp = {ovf_sel, cap_val};
    ticks     = timestamp - first_ts_q;
  end

  // Jump test against the newest history entry, skipped when it is zero or the history is empty.
  assign jump = (fill_q != '0) && (last_q != '0) &&
                (({raw_q, 1'b0} < {1'b0, last_q}) || ({1'b0, raw_q} > {last_q, 1'b0}));

  assign wr_pos  = cleared_q ? '0 : pos_q;
  assign hz_sum  = {1'b0, smooth_q} + (FREQ_W + 1)'(128);
  assign hz_x60  = {hz_q, 6'b0} - {4'b0, hz_q, 2'b0};
  assign ppr_eff = (ppr_q == '0) ? PPR_W'(1) : ppr_q;

  // The divider is shared by the three divisions of a measurement.
  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_RAW_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({prod_q, {Q8_BITS{1'b0}}}) + DIV_W'(ticks_q[31:1]);
        div_req.divisor  = ticks_q;
      end
      ST_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(acc_q) + DIV_W'(fill_q >> 1);
        div_req.divisor  = DVS_W'(fill_q);
      end
      ST_RPM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(hz_x60);
        div_req.divisor  = DVS_W'(ppr_eff);
      end
      default: begin
      end
    endcase
  end

  cfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clock_q <= RST_TIMER_CLOCK;
      low_band_q    <= RST_LOW_BAND;
      high_band_q   <= RST_HIGH_BAND;
      window_low_q  <= RST_WINDOW_LOW;
      window_mid_q  <= RST_WINDOW_MID;
      window_high_q <= RST_WINDOW_HIGH;
      ppr_q         <= RST_PPR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TIMER_CLOCK:    timer_clock_q <= cfg_data_i;
        REG_LOW_BAND:       low_band_q    <= cfg_data_i;
        REG_HIGH_BAND:      high_band_q   <= cfg_data_i;
        REG_WINDOW_LOW:     window_low_q  <= cfg_data_i[WCFG_W-1:0];
        REG_WINDOW_MID:     window_mid_q  <= cfg_data_i[WCFG_W-1:0];
        REG_WINDOW_HIGH:    window_high_q <= cfg_data_i[WCFG_W-1:0];
        REG_PULSES_PER_REV: ppr_q         <= cfg_data_i[PPR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // History memory: one write while storing, one registered read per entry while summing.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) begin
      ring_mem[wr_pos] <= raw_q;
    end
    if (state_q == ST_SUM_RD) begin
      ring_rd_q <= ring_mem[idx_q];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ovf_cnt_q     <= '0;
      first_ts_q    <= '0;
      edge_cnt_q    <= '0;
      window_size_q <= WinReset;
      pos_q         <= '0;
      fill_q        <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // A taken result frees the output register; the final step refills it
      // in the same cycle on its own.
      if (m_axis_tready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser_i[0] == OP_OVERFLOW) begin
              ovf_cnt_q <= ovf_cnt_q + CAP_W'(1);
            end else begin
              if (edge_cnt_q == '0) begin
                first_ts_q <= timestamp;
              end
              if (edge_cnt_q >= window_size_q) begin
                // This edge closes the window; an empty span is dropped.
                edge_cnt_q <= '0;
                ticks_q    <= ticks;
                win_q      <= window_size_q;
                if (ticks != '0) begin
                  state_q <= ST_MUL;
                end
              end else begin
                edge_cnt_q <= edge_cnt_q + WIN_W'(1);
              end
            end
          end
        end

        ST_MUL: begin
          prod_q  <= PROD_W'(timer_clock_q * win_q);
          state_q <= ST_RAW_GO;
        end

        ST_RAW_GO: state_q <= ST_RAW_WAIT;

        ST_RAW_WAIT: begin
          if (div_rsp.done) begin
            raw_q   <= sat_freq(div_rsp.quotient);
            state_q <= ST_BAND;
          end
        end

        ST_BAND: begin
          priority if (raw_q < {low_band_q, {Q8_BITS{1'b0}}}) begin
            window_size_q <= clamp_win(window_low_q);
          end else if (raw_q < {high_band_q, {Q8_BITS{1'b0}}}) begin
            window_size_q <= clamp_win(window_mid_q);
          end else begin
            window_size_q <= clamp_win(window_high_q);
          end
          cleared_q <= jump;
          state_q   <= ST_STORE;
        end

        ST_STORE: begin
          // After a jump the history restarts at slot zero; only the slots
          // below the fill count are ever summed, so no clearing is needed.
          pos_q  <= (wr_pos == LastIdx) ? '0 : wr_pos + IDX_W'(1);
          if (cleared_q) begin
            fill_q <= FILL_W'(1);
          end else if (fill_q < FullFill) begin
            fill_q <= fill_q + FILL_W'(1);
          end
          last_q  <= raw_q;
          acc_q   <= '0;
          idx_q   <= '0;
          state_q <= ST_SUM_RD;
        end

        ST_SUM_RD: state_q <= ST_SUM_ACC;

        ST_SUM_ACC: begin
          acc_q <= acc_q + ACC_W'(ring_rd_q);
          if (FILL_W'(idx_q) + FILL_W'(1) == fill_q) begin
            state_q <= ST_AVG_GO;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= ST_SUM_RD;
          end
        end

        ST_AVG_GO: state_q <= ST_AVG_WAIT;

        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            smooth_q <= sat_freq(div_rsp.quotient);
            state_q  <= ST_HZ;
          end
        end

        ST_HZ: begin
          hz_q    <= hz_sum[FREQ_W] ? '1 : hz_sum[FREQ_W-1:Q8_BITS];
          state_q <= ST_RPM_GO;
        end

        ST_RPM_GO: state_q <= ST_RPM_WAIT;

        ST_RPM_WAIT: begin
          if (div_rsp.done) begin
            rpm_q   <= div_rsp.quotient[RPM_W-1:0];
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, NWIN_W'(window_size_q), rpm_q, hz_q, smooth_q, raw_q};
            out_user_q  <= cleared_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_user_q;

endmodule

[sv/cfm_checker.sv]
module cfm_checker
  import cfm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]             m_axis_tuser_o
);

  logic [FREQ_W-1:0] raw;
  logic [FREQ_W-1:0] smooth;
  logic [HZ_W-1:0]   hz;
  logic [NWIN_W-1:0] nwin;
  logic [FREQ_W:0]   hz_sum;
  logic [HZ_W-1:0]   hz_exp;

  always_comb begin
    raw    = m_axis_tdata_o[RAW_LSB +: FREQ_W];
    smooth = m_axis_tdata_o[SMOOTH_LSB +: FREQ_W];
    hz     = m_axis_tdata_o[HZ_LSB +: HZ_W];
    nwin   = m_axis_tdata_o[NWIN_LSB +: NWIN_W];
    hz_sum = {1'b0, smooth} + (FREQ_W + 1)'(128);
    hz_exp = hz_sum[FREQ_W] ? '1 : hz_sum[FREQ_W-1:Q8_BITS];
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A restarted average holds only the newest value.
  a_cleared_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> smooth == raw)
    else $error("cleared average differs from the window frequency");

  // Hz is the average rounded from Q.8 and saturated.
  a_hz_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> hz == hz_exp)
    else $error("freq_hz does not match the rounded average");

  // The next window always lies within the supported range.
  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (nwin != '0) && (nwin <= NWIN_W'(MAX_WINDOW)))
    else $error("next window out of range");

endmodule

bind capture_frequency_meter cfm_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_cfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
